@@ rtl/rpn_pkg.sv @@
// package: operation and status codes and sizes for the rpn stack calculator
package rpn_pkg;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned DefaultStackDepth = 256;

  localparam logic [3:0] OP_PUSH = 4'd0;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_MUL = 4'd3;
  localparam logic [3:0] OP_DIV = 4'd4;
  localparam logic [3:0] OP_POW = 4'd5;
  localparam logic [3:0] OP_ABS = 4'd6;
  localparam logic [3:0] OP_NEG = 4'd7;
  localparam logic [3:0] OP_NOT = 4'd8;
  localparam logic [3:0] OP_END = 4'd10;
  localparam logic [3:0] OP_INV = 4'd11;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INV = 3'd1;
  localparam logic [2:0] ST_OVF = 3'd2;
  localparam logic [2:0] ST_UNF = 3'd3;
  localparam logic [2:0] ST_DIV = 3'd4;

  typedef logic [DataWidth-1:0] word_t;
endpackage

@@ rtl/rpn_stack_calculator.sv @@
// top level: reverse-polish stack calculator with bit-serial arithmetic
//
// Input channel: operation and number with in_valid / in_stall. Output
// channel: result_value and status with out_valid / out_stall, one word per
// end-of-line token. Tokens are handled one at a time.
// push, abs, neg, not, nop and unknown codes: accepted, no stall.
// add and sub: the accept step and one pop refill of the second register
// from the stack memory.
// mul runs one bit per cycle through shift registers: accept, 32 steps and
// the pop refill. div: accept, 32 steps, sign fix-up and pop refill. pow
// squares and multiplies through the same serial multiplier; with up to 31
// exponent bits that is at most 61 products, and that loop sets the worst
// case.
// End of line loads the output register; the next token is taken while the
// result waits, but a second end of line waits until the first is taken.
// Reset empties the stack, clears the error and drops any waiting result.
// While the receiver stalls, the result word holds unchanged.
// The stack memory needs no clearing: only written entries are read.
module rpn_stack_calculator
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DefaultStackDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  operation,
  input  logic signed [31:0] number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] result_value,
  output logic [2:0]  status
);
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AdrW = (STACK_DEPTH > 3) ? $clog2(STACK_DEPTH - 2) : 1;
  localparam int unsigned MemD = (STACK_DEPTH > 2) ? STACK_DEPTH - 2 : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_POWB = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;
  localparam logic [2:0] S_DFIN = 3'd5;

  logic [2:0] state;
  word_t top_reg, second_reg;
  logic [CntW-1:0] entry_count;
  logic [2:0] sticky_error;
  logic skip_rest;
  word_t mem [MemD];
  word_t rd_data;

  // serial unit registers
  word_t acc, mcand, mplier;       // multiply: acc += mcand when mplier lsb
  word_t rem_r, quo;               // divide: restoring remainder and quotient
  word_t dvs;
  logic neg_q;
  logic [5:0] cnt;
  word_t pbase, pexp, pacc;
  logic pstep;                     // 0: acc*base, 1: base*base
  logic pow_mode;

  logic accept, in_fire;
  logic [AdrW-1:0] spill_adr, pop_adr;

  assign spill_adr = AdrW'(entry_count - CntW'(2));
  assign pop_adr = AdrW'(entry_count - CntW'(3));
  assign in_stall = (state != S_IDLE) || (operation == OP_END && out_valid);
  assign in_fire = in_valid && !in_stall;
  assign accept = in_fire && !skip_rest && sticky_error == ST_OK;

  // remainder trial subtract for divide
  logic [DataWidth:0] trial;
  assign trial = {rem_r, quo[DataWidth-1]} - {1'b0, dvs};

  // power mode flag: set when a pow starts, cleared on mul start
  always_ff @(posedge clk) begin
    if (rst) pow_mode <= 1'b0;
    else if (accept && operation == OP_MUL) pow_mode <= 1'b0;
    else if (accept && operation == OP_POW) pow_mode <= 1'b1;
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (accept && operation == OP_PUSH && entry_count >= CntW'(2) &&
        entry_count < CntW'(STACK_DEPTH))
      mem[spill_adr] <= second_reg;
    rd_data <= mem[pop_adr];
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      top_reg <= '0;
      entry_count <= '0;
      sticky_error <= ST_OK;
      skip_rest <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire && operation == OP_END) begin
            out_valid <= 1'b1;
            result_value <= (sticky_error == ST_OK && entry_count != '0) ? top_reg : '0;
            status <= sticky_error;
            entry_count <= '0;
            top_reg <= '0;
            sticky_error <= ST_OK;
            skip_rest <= 1'b0;
          end else if (accept) begin
            priority if (operation == OP_PUSH) begin
              if (entry_count >= CntW'(STACK_DEPTH)) sticky_error <= ST_OVF;
              else begin
                if (entry_count != '0) second_reg <= top_reg;
                top_reg <= number;
                entry_count <= entry_count + CntW'(1);
              end
            end else if (operation >= OP_ADD && operation <= OP_POW) begin
              if (entry_count < CntW'(2)) sticky_error <= ST_UNF;
              else begin
                unique case (operation)
                  OP_ADD: begin
                    top_reg <= top_reg + second_reg;
                    state <= S_FILL;
                  end
                  OP_SUB: begin
                    top_reg <= top_reg - second_reg;
                    state <= S_FILL;
                  end
                  OP_MUL: begin
                    acc <= '0; mcand <= top_reg; mplier <= second_reg;
                    cnt <= '0; state <= S_MUL;
                  end
                  OP_DIV: begin
                    if (second_reg == '0 ||
                        (top_reg == 32'h8000_0000 && second_reg == '1))
                      sticky_error <= ST_DIV;
                    else begin
                      rem_r <= '0;
                      quo <= top_reg[31] ? -top_reg : top_reg;
                      dvs <= second_reg[31] ? -second_reg : second_reg;
                      neg_q <= top_reg[31] ^ second_reg[31];
                      cnt <= '0; state <= S_DIV;
                    end
                  end
                  default: begin
                    if (second_reg[31]) begin
                      top_reg <= '0; state <= S_FILL;
                    end else begin
                      pbase <= top_reg; pexp <= second_reg; pacc <= 32'd1;
                      state <= S_POWB;
                    end
                  end
                endcase
              end
            end else if (operation >= OP_ABS && operation <= OP_NOT) begin
              if (entry_count == '0) sticky_error <= ST_UNF;
              else if (operation == OP_ABS) top_reg <= top_reg[31] ? -top_reg : top_reg;
              else if (operation == OP_NEG) top_reg <= -top_reg;
              else top_reg <= ~top_reg;
            end else if (operation == OP_INV) begin
              sticky_error <= ST_INV;
              skip_rest <= 1'b1;
            end else begin
              // nop and unknown codes leave everything as it is
            end
          end
        end
        // one multiplier bit per cycle
        S_MUL: begin
          if (mplier[0]) acc <= acc + mcand;
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
          cnt <= cnt + 6'd1;
        end
        // one quotient bit per cycle
        S_DIV: begin
          if (!trial[DataWidth]) rem_r <= trial[DataWidth-1:0];
          else rem_r <= {rem_r[DataWidth-2:0], quo[DataWidth-1]};
          quo <= {quo[DataWidth-2:0], ~trial[DataWidth]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) state <= S_DFIN;
        end
        S_DFIN: begin
          top_reg <= neg_q ? -quo : quo;
          state <= S_FILL;
        end
        // power: choose next product or finish
        S_POWB: begin
          if (pexp == '0) begin
            top_reg <= pacc;
            state <= S_FILL;
          end else begin
            acc <= '0; cnt <= '0; state <= S_MUL;
            if (pexp[0]) begin
              mcand <= pacc; mplier <= pbase; pstep <= 1'b0;
            end else begin
              mcand <= pbase; mplier <= pbase; pstep <= 1'b1;
            end
          end
        end
        // pop: refill second from memory
        default: begin
          entry_count <= entry_count - CntW'(1);
          if (entry_count >= CntW'(3)) second_reg <= rd_data;
          state <= S_IDLE;
        end
      endcase
      // multiply completion
      if (state == S_MUL && cnt == 6'd31) begin
        if (pow_mode) begin
          if (pstep) begin
            pbase <= mplier[0] ? acc + mcand : acc;
            pexp <= pexp >> 1;
          end else begin
            pacc <= mplier[0] ? acc + mcand : acc;
            pexp[0] <= 1'b0;
          end
          state <= S_POWB;
        end else begin
          top_reg <= mplier[0] ? acc + mcand : acc;
          state <= S_FILL;
        end
      end
    end
  end
endmodule

@@ sim/rpn_stack_calculator_tb.sv @@
// testbench: rpn stack calculator, directed and random token lines checked against a behavioural predictor
`timescale 1ns / 100ps

module rpn_stack_calculator_tb
  import rpn_pkg::*;
;

  localparam int unsigned Depth = DefaultStackDepth;
  localparam int unsigned IdleLimit = 20000;
  localparam logic [3:0] OP_NOP = 4'd9;

  // scoreboard: tracks calculator state and queues expected end-of-line words
  class rpn_scoreboard;
    word_t top_q, second_q;
    word_t spill_q [Depth];
    int unsigned count_q;
    logic [2:0] err_q;
    bit skip_q;
    word_t want_value [$];
    logic [2:0] want_status [$];
    int unsigned fails;

    function new();
      top_q = '0;
      second_q = '0;
      count_q = 0;
      err_q = ST_OK;
      skip_q = 0;
      fails = 0;
    endfunction

    function void flag(logic [2:0] code);
      if (err_q == ST_OK) err_q = code;
    endfunction

    function word_t magnitude(word_t v);
      return v[31] ? -v : v;
    endfunction

    function word_t power(word_t b, word_t e);
      word_t acc;
      acc = 1;
      if (e[31]) return '0;
      while (e != 0) begin
        if (e[0]) acc = acc * b;
        b = b * b;
        e = e >> 1;
      end
      return acc;
    endfunction

    // note an accepted token
    function void note_token(logic [3:0] op, word_t num);
      word_t a, b, r;
      a = top_q;
      b = second_q;
      r = '0;
      if (op == OP_END) begin
        want_value.push_back((err_q == ST_OK && count_q > 0) ? top_q : '0);
        want_status.push_back(err_q);
        count_q = 0;
        top_q = '0;
        err_q = ST_OK;
        skip_q = 0;
        return;
      end
      if (skip_q || err_q != ST_OK) return;
      case (op)
        OP_PUSH: begin
          if (count_q >= Depth) flag(ST_OVF);
          else begin
            if (count_q >= 2) spill_q[count_q-2] = second_q;
            if (count_q >= 1) second_q = top_q;
            top_q = num;
            count_q++;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW: begin
          if (count_q < 2) flag(ST_UNF);
          else if (op == OP_DIV && (b == 0 || (a == 32'h8000_0000 && b == '1)))
            flag(ST_DIV);
          else begin
            case (op)
              OP_ADD: r = a + b;
              OP_SUB: r = a - b;
              OP_MUL: r = a * b;
              OP_DIV: begin
                r = magnitude(a) / magnitude(b);
                if (a[31] ^ b[31]) r = -r;
              end
              default: r = power(a, b);
            endcase
            count_q--;
            top_q = r;
            if (count_q >= 2) second_q = spill_q[count_q-2];
          end
        end
        OP_ABS, OP_NEG, OP_NOT: begin
          if (count_q < 1) flag(ST_UNF);
          else if (op == OP_ABS) top_q = magnitude(top_q);
          else if (op == OP_NEG) top_q = -top_q;
          else top_q = ~top_q;
        end
        OP_INV: begin
          flag(ST_INV);
          skip_q = 1;
        end
        default: ;
      endcase
    endfunction

    // check a result word against the oldest expectation
    function void check_word(word_t value, logic [2:0] st);
      word_t ev;
      logic [2:0] es;
      if (want_value.size() == 0) begin
        $error("unexpected result word value=%0d status=%0d", $signed(value), st);
        fails++;
        return;
      end
      ev = want_value.pop_front();
      es = want_status.pop_front();
      if (value !== ev) begin
        $error("result_value expected %0d actual %0d", $signed(ev), $signed(value));
        fails++;
      end
      if (st !== es) begin
        $error("status expected %0d actual %0d", es, st);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return want_value.size();
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [3:0] operation;
  logic signed [31:0] number, result_value;
  logic [2:0] status;

  rpn_scoreboard board;
  bit quiet_sender, quiet_receiver, receiver_hold;
  int unsigned idle_cycles, line_len;

  rpn_stack_calculator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .number(number),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .status(status)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // offer one word and wait for acceptance, with random gaps
  task automatic send_word(logic [3:0] op, word_t num);
    while (!quiet_sender && $urandom_range(99) < 15) begin
      in_valid <= 0;
      @(negedge clk);
    end
    operation <= op;
    number <= num;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    board.note_token(op, num);
    @(negedge clk);
  endtask

  // withdraw the offer before the sender waits
  task automatic drop_valid();
    in_valid <= 0;
  endtask

  function automatic word_t pick_number();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      4: return $urandom_range(3);
      5: return $urandom;
      default: return $urandom_range(40) - 20;
    endcase
  endfunction

  // exponents stay small mostly so pow keeps the run short
  function automatic word_t pick_exponent();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom;
      default: return $urandom_range(12);
    endcase
  endfunction

  // a well-formed line: pushes and operators keeping depth legal
  task automatic send_line(int unsigned len);
    int unsigned depth;
    int unsigned k;
    logic [3:0] op;
    depth = 0;
    for (k = 0; k < len; k++) begin
      if (depth < 2 || $urandom_range(2) == 0) begin
        send_word(OP_PUSH, ($urandom_range(5) == 0) ? pick_exponent() : pick_number());
        depth++;
      end else begin
        op = 4'($urandom_range(OP_ADD, OP_NOT));
        send_word(op, $urandom);
        if (op <= OP_POW) depth--;
      end
    end
    send_word(OP_END, $urandom);
  endtask

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (rst) out_stall <= 0;
    else if (receiver_hold) out_stall <= 1;
    else out_stall <= !quiet_receiver && ($urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_word(result_value, status);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned j;
    board = new();
    rst = 1;
    in_valid = 0;
    operation = OP_NOP;
    number = '0;
    quiet_sender = 0;
    quiet_receiver = 0;
    receiver_hold = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empty line, add, abs, neg, not, div, pow, faults and special cases
    send_word(OP_END, '0);
    send_word(OP_ADD, '0); send_word(OP_END, '0);
    send_word(OP_ABS, '0); send_word(OP_END, '0);
    send_word(OP_PUSH, 32'h8000_0000); send_word(OP_ABS, '0); send_word(OP_NEG, '0);
    send_word(OP_NOT, '0); send_word(OP_END, '0);
    send_word(OP_PUSH, '1); send_word(OP_PUSH, 32'h8000_0000); send_word(OP_DIV, '0);
    send_word(OP_END, '0);
    send_word(OP_PUSH, '0); send_word(OP_PUSH, 32'h7fff_ffff); send_word(OP_DIV, '0);
    send_word(OP_END, '0);
    send_word(OP_PUSH, 3); send_word(OP_PUSH, -7); send_word(OP_DIV, '0);
    send_word(OP_PUSH, 10); send_word(OP_POW, '0); send_word(OP_END, '0);
    send_word(OP_PUSH, -1); send_word(OP_PUSH, 5); send_word(OP_POW, '0);
    send_word(OP_END, '0);
    send_word(OP_PUSH, 4); send_word(OP_INV, '0); send_word(OP_PUSH, 9);
    send_word(OP_END, '0);
    send_word(OP_PUSH, 6); send_word(4'd12, '1); send_word(4'd15, '0);
    send_word(OP_NOP, '0); send_word(OP_END, '0);

    // overflow: fill the stack then one more push
    for (j = 0; j <= Depth; j++) send_word(OP_PUSH, $urandom);
    send_word(OP_END, '0);
    // deep stack folded down by adds and subs
    for (j = 0; j < Depth; j++) send_word(OP_PUSH, $urandom);
    for (j = 1; j < Depth; j++) send_word(j[0] ? OP_ADD : OP_SUB, '0);
    send_word(OP_END, '0);

    // long receiver hold-off while lines keep coming
    fork
      begin
        receiver_hold = 1;
        repeat (3000) @(negedge clk);
        receiver_hold = 0;
      end
      repeat (4) send_line(3);
    join

    // sender pause until every result is back
    drop_valid();
    while (board.pending() != 0) @(negedge clk);

    sent = 0;
    while (sent < 880) begin
      quiet_sender = (sent > 300 && sent < 550);
      quiet_receiver = quiet_sender;
      if ($urandom_range(9) == 0) begin
        // noise: any code, any value
        send_word(4'($urandom_range(15)), $urandom);
        sent++;
      end else begin
        line_len = $urandom_range(1, 10);
        send_line(line_len);
        sent += line_len + 1;
      end
    end
    quiet_sender = 0;
    quiet_receiver = 0;
    send_word(OP_END, '0);
    drop_valid();

    while (board.pending() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (board.fails == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/rpn_pkg.sv
rtl/rpn_stack_calculator.sv
sim/rpn_stack_calculator_tb.sv
